FILE: design/lbs_pkg.sv
// Shared types and constants for the lower-bound search block.
// Used by lbs_ctrl, lbs_datapath and lower_bound_search_top; no dependencies.
`default_nettype none
package lbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int POS_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_STEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic wr;
    logic load;
    logic first;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic first_more;
    logic step_more;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: design/lbs_ctrl.sv
// Controller state machine for the lower-bound search block.
// Depends on lbs_pkg; drives lbs_datapath through dp_cmd_t and reads dp_stat_t.
`default_nettype none
module lbs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             in_cmd,
  input  wire lbs_pkg::dp_stat_t stat,
  output lbs_pkg::dp_cmd_t      cmd,
  output logic                  busy,
  output logic                  out_valid
);

  lbs_pkg::state_t state_r;
  lbs_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lbs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lbs_pkg::ST_IDLE: begin
        if (start && in_cmd == lbs_pkg::CMD_SEARCH) begin
          state_nxt = lbs_pkg::ST_ISSUE;
        end
      end
      lbs_pkg::ST_ISSUE: begin
        state_nxt = stat.first_more ? lbs_pkg::ST_STEP : lbs_pkg::ST_DONE;
      end
      lbs_pkg::ST_STEP: begin
        state_nxt = stat.step_more ? lbs_pkg::ST_STEP : lbs_pkg::ST_DONE;
      end
      lbs_pkg::ST_DONE: begin
        state_nxt = lbs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      lbs_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.wr   = start && in_cmd == lbs_pkg::CMD_WRITE;
        cmd.load = start && in_cmd == lbs_pkg::CMD_SEARCH;
      end
      lbs_pkg::ST_ISSUE: begin
        cmd.first = 1'b1;
      end
      lbs_pkg::ST_STEP: begin
        cmd.step = 1'b1;
      end
      lbs_pkg::ST_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: design/lbs_datapath.sv
// Datapath for the lower-bound search block: table memory, search bounds, compare.
// Depends on lbs_pkg; commanded by lbs_ctrl.
`default_nettype none
module lbs_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire lbs_pkg::dp_cmd_t                  cmd,
  input  wire logic                              cfg_we,
  input  wire logic [lbs_pkg::POS_W-1:0]         cfg_table_length,
  input  wire logic [lbs_pkg::ADDR_W-1:0]        in_index,
  input  wire logic signed [lbs_pkg::DATA_W-1:0] in_value,
  output lbs_pkg::dp_stat_t                      stat,
  output logic [lbs_pkg::POS_W-1:0]              out_position
);

  localparam logic [lbs_pkg::POS_W-1:0] ONE   = lbs_pkg::POS_W'(1);
  localparam logic [lbs_pkg::POS_W-1:0] TWO   = lbs_pkg::POS_W'(2);
  localparam logic [lbs_pkg::POS_W-1:0] DEPTH = lbs_pkg::POS_W'(lbs_pkg::TABLE_DEPTH);

  logic signed [lbs_pkg::DATA_W-1:0] mem [lbs_pkg::TABLE_DEPTH];

  logic [lbs_pkg::POS_W-1:0]         len_r;
  logic [lbs_pkg::POS_W-1:0]         lo_r, lo_nxt;
  logic [lbs_pkg::POS_W-1:0]         hi_r, hi_nxt;
  logic [lbs_pkg::POS_W-1:0]         mid_r, mid_nxt;
  logic signed [lbs_pkg::DATA_W-1:0] tgt_r;
  logic signed [lbs_pkg::DATA_W-1:0] rdata_r;

  logic [lbs_pkg::POS_W-1:0] used;
  logic [lbs_pkg::POS_W-1:0] mid0, mid_left, mid_right;
  logic                      ge, more_left, more_right, rd_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_we) begin
      len_r <= cfg_table_length;
    end
  end

  assign used = (len_r > DEPTH) ? DEPTH : len_r;

  assign mid0       = lo_r + ((hi_r - ONE - lo_r) >> 1);
  assign ge         = rdata_r >= tgt_r;
  assign mid_left   = lo_r + ((mid_r - ONE - lo_r) >> 1);
  assign mid_right  = mid_r + ONE + ((hi_r - TWO - mid_r) >> 1);
  assign more_left  = lo_r < mid_r;
  assign more_right = (mid_r + ONE) < hi_r;

  assign stat.first_more = lo_r < hi_r;
  assign stat.step_more  = ge ? more_left : more_right;

  always_comb begin
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    mid_nxt = mid_r;
    rd_en   = 1'b0;
    if (cmd.load) begin
      lo_nxt = '0;
      hi_nxt = used;
    end else if (cmd.first) begin
      mid_nxt = mid0;
      rd_en   = stat.first_more;
    end else if (cmd.step) begin
      if (ge) begin
        hi_nxt  = mid_r;
        mid_nxt = mid_left;
      end else begin
        lo_nxt  = mid_r + ONE;
        mid_nxt = mid_right;
      end
      rd_en = stat.step_more;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    if (cmd.load) begin
      tgt_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[in_index] <= in_value;
    end
    if (rd_en) begin
      rdata_r <= mem[mid_nxt[lbs_pkg::ADDR_W-1:0]];
    end
  end

  assign out_position = lo_r;

endmodule
`default_nettype wire

FILE: design/lower_bound_search_top.sv
// Top level of the lower-bound search block.
// Depends on lbs_pkg, lbs_ctrl and lbs_datapath.
//
// Usage:
//   Input items are taken on start while busy is low. in_cmd selects a write
//   (in_value stored at in_index, no result) or a search for in_value.
//   A write leaves busy low, so writes stream back to back.
//   A search raises busy and returns the index of the first entry not less
//   than the target in out_position, marked by a one-cycle out_valid pulse.
//   After the accepting edge the controller passes through ISSUE (first read),
//   one STEP state per halving step (none for an empty table) and DONE, which
//   raises out_valid; it then returns to IDLE, where the next item is taken.
//   Each step is one read of the table memory plus one compare, so the memory
//   port sets the rate. cfg_table_length is written with cfg_we; the user must
//   write it only while idle, the block does not enforce this. Values above 1024
//   search the full table. Reset clears the length and control state; table
//   contents are undefined until written. The receiver cannot stall results.
`default_nettype none
module lower_bound_search_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_cmd,
  input  wire logic [lbs_pkg::ADDR_W-1:0]        in_index,
  input  wire logic signed [lbs_pkg::DATA_W-1:0] in_value,
  output logic                                   out_valid,
  output logic [lbs_pkg::POS_W-1:0]              out_position,
  input  wire logic                              cfg_we,
  input  wire logic [lbs_pkg::POS_W-1:0]         cfg_table_length
);

  lbs_pkg::dp_cmd_t  cmd;
  lbs_pkg::dp_stat_t stat;

  lbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_cmd    (in_cmd),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  lbs_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_we           (cfg_we),
    .cfg_table_length (cfg_table_length),
    .in_index         (in_index),
    .in_value         (in_value),
    .stat             (stat),
    .out_position     (out_position)
  );

endmodule
`default_nettype wire

FILE: bench/lower_bound_search_top_tb.sv
// Self-checking bench for lower_bound_search_top: sorted, unsorted and noisy tables,
// lengths from empty to saturated, searches checked against an in-bench binary search.
// Depends on lbs_pkg and lower_bound_search_top.
`default_nettype none
module lower_bound_search_top_tb;
  import lbs_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1800;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] index;
    logic [DATA_W-1:0] value;
  } lbs_item_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     in_cmd = CMD_WRITE;
  logic [ADDR_W-1:0]        in_index = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic [POS_W-1:0]         out_position;
  logic                     cfg_we = 1'b0;
  logic [POS_W-1:0]         cfg_table_length = '0;

  lbs_item_t        item_q[$];
  logic [POS_W-1:0] position_q[$];
  lbs_item_t        next_item;
  logic [POS_W-1:0] want_pos;

  // predictor state, updated as items are accepted
  logic [DATA_W-1:0] entry_mem [TABLE_DEPTH];
  logic [POS_W-1:0]  len_reg = '0;
  // generator view of the table, updated as items are queued
  logic [DATA_W-1:0] plan_mem [TABLE_DEPTH];
  bit                written [TABLE_DEPTH];
  int                written_cnt = 0;

  int idle_pct = 0;
  int fails = 0;
  int n_writes = 0;
  int n_searches = 0;
  int n_past_end = 0;
  int n_lengths = 0;
  int stall_cycles = 0;

  lower_bound_search_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_index         (in_index),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_position     (out_position),
    .cfg_we           (cfg_we),
    .cfg_table_length (cfg_table_length)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [POS_W-1:0] lower_bound_of(logic [DATA_W-1:0] target);
    int used;
    int lo;
    int hi;
    int mid;
    int found;
    used = (len_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(len_reg);
    lo = 0;
    hi = used - 1;
    found = used;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if ($signed(entry_mem[mid]) >= $signed(target)) begin
        found = mid;
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return found[POS_W-1:0];
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (in_cmd == CMD_WRITE) begin
          entry_mem[in_index] = in_value;
          n_writes++;
        end else begin
          position_q.push_back(lower_bound_of(in_value));
          if (position_q[$] == ((len_reg > TABLE_DEPTH) ? TABLE_DEPTH : len_reg))
            n_past_end++;
          n_searches++;
        end
      end
      if (!start || !busy) begin
        if (item_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_item = item_q.pop_front();
          start    <= 1'b1;
          in_cmd   <= next_item.cmd;
          in_index <= next_item.index;
          in_value <= next_item.value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (position_q.size() == 0) begin
        $error("position: expected none, actual %0d", out_position);
        fails++;
      end else begin
        want_pos = position_q.pop_front();
        if (out_position !== want_pos) begin
          $error("position: expected %0d, actual %0d", want_pos, out_position);
          fails++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || cfg_we) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("[lower_bound_search_top] ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic push_write(int idx, logic [DATA_W-1:0] val);
    item_q.push_back('{cmd: CMD_WRITE, index: idx[ADDR_W-1:0], value: val});
    plan_mem[idx] = val;
    if (!written[idx]) begin
      written[idx] = 1'b1;
      written_cnt++;
    end
  endtask

  task automatic push_search(logic [DATA_W-1:0] target);
    item_q.push_back('{cmd: CMD_SEARCH, index: ADDR_W'($urandom()), value: target});
  endtask

  // wait until the block has drained every item and result
  task automatic settle();
    @(negedge clk);
    while (item_q.size() != 0 || start || position_q.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic set_length(logic [POS_W-1:0] n);
    settle();
    @(posedge clk);
    cfg_we           <= 1'b1;
    cfg_table_length <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    len_reg = n;
    n_lengths++;
    @(negedge clk);
  endtask

  // ascending content with duplicates; one table in five is scrambled
  task automatic fill_prefix(int n);
    longint cur;
    longint span;
    bit     scramble;
    scramble = ($urandom_range(4) == 0);
    cur = ($urandom_range(3) == 0) ? -64'sd2147483648 : longint'($signed($urandom()));
    span = (n == 0) ? 0 : (64'sd2147483647 - cur) / n;
    for (int i = 0; i < n; i++) begin
      if (scramble) begin
        push_write(i, $urandom());
      end else begin
        if ($urandom_range(3) != 0 && span > 0)
          cur = cur + longint'($urandom_range(span[31:0], 0));
        push_write(i, cur[DATA_W-1:0]);
      end
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_target(int n);
    logic [DATA_W-1:0] t;
    int r;
    r = $urandom_range(99);
    if (n == 0 || r < 15) begin
      t = $urandom();
    end else if (r < 25) begin
      t = (r < 20) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      t = plan_mem[$urandom_range(n - 1)];
      if (r >= 85) t = t + 1;
      else if (r >= 70) t = t - 1;
    end
    return t;
  endfunction

  initial begin
    int idle_mix [4];
    int ph;
    int len;
    int fill;
    int n_items;
    int random_items;
    idle_mix = '{0, 45, 0, 28};
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      entry_mem[i] = '0;
      plan_mem[i]  = '0;
      written[i]   = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table after reset
    push_search(32'h8000_0000);
    push_search(32'h7FFF_FFFF);
    push_search(32'h0000_0000);
    push_write(0, 32'h8000_0000);
    push_write(1, -5);
    push_write(2, -5);
    push_write(3, 0);
    push_write(4, 7);
    push_write(5, 32'h7FFF_FFFF);
    push_write(TABLE_DEPTH - 1, 32'h5A5A_A5A5);
    set_length(6);
    push_search(32'h8000_0000);
    push_search(-6);
    push_search(-5);
    push_search(-4);
    push_search(0);
    push_search(1);
    push_search(8);
    push_search(32'h7FFF_FFFF);
    set_length(5);
    push_search(32'h7FFF_FFFF);
    push_search(7);

    random_items = 0;
    ph = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (ph)
        0: len = 1;
        1: len = 0;
        2: len = TABLE_DEPTH;
        5: len = 2047;
        default: begin
          if (written_cnt == TABLE_DEPTH && $urandom_range(9) == 0)
            len = $urandom_range(2047, TABLE_DEPTH + 1);
          else if ($urandom_range(11) == 0)
            len = 0;
          else
            len = $urandom_range(48, 1);
        end
      endcase
      fill = (len > TABLE_DEPTH) ? TABLE_DEPTH : len;
      set_length(len[POS_W-1:0]);
      idle_pct = idle_mix[ph % 4];
      n_items = item_q.size();
      if (fill <= 64 || written_cnt != TABLE_DEPTH) fill_prefix(fill);
      for (int s = $urandom_range(20, 6); s > 0; s--) begin
        if ($urandom_range(9) == 0)
          push_write($urandom_range(TABLE_DEPTH - 1), $urandom());
        push_search(pick_target(fill));
      end
      random_items += item_q.size() - n_items;
      ph++;
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Ran %0d writes and %0d searches across %0d table lengths (0 to 2047),",
             n_writes, n_searches, n_lengths);
    $display("with %0d searches past the last entry and sender gaps of 0, 28 and 45 percent.",
             n_past_end);
    if (fails == 0) begin
      $display("[lower_bound_search_top] OK");
    end else begin
      $display("[lower_bound_search_top] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: lower_bound_search_top.f
design/lbs_pkg.sv
design/lbs_ctrl.sv
design/lbs_datapath.sv
design/lower_bound_search_top.sv
bench/lower_bound_search_top_tb.sv
